### hdl/rrc_pkg.sv
// shared types, codes and limits of the resync request controller
// no dependencies
package rrc_pkg;

  localparam int GEN_BITS = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [2:0] op_t;
  localparam op_t OP_DELTA_OK    = 3'd0;
  localparam op_t OP_KEY_OK      = 3'd1;
  localparam op_t OP_LEGACY_FAIL = 3'd2;
  localparam op_t OP_CANON_OK    = 3'd3;
  localparam op_t OP_CANON_FAIL  = 3'd4;
  localparam op_t OP_FORCE       = 3'd5;
  localparam op_t OP_TICK        = 3'd6;
  localparam op_t OP_INVALID     = 3'd7;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK  = 2'd0;
  localparam status_t ST_EXH = 2'd1;
  localparam status_t ST_CFG = 2'd2;
  localparam status_t ST_BAD = 2'd3;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_LEGACY_THR = 3'd0;
  localparam reg_idx_t REG_CANON_THR  = 3'd1;
  localparam reg_idx_t REG_BURST      = 3'd2;
  localparam reg_idx_t REG_COOLDOWN   = 3'd3;

  localparam logic [10:0] LEGACY_THR_RST = 11'd1;
  localparam logic [10:0] CANON_THR_RST  = 11'd3;
  localparam logic [6:0]  BURST_RST      = 7'd3;
  localparam logic [12:0] COOLDOWN_RST   = 13'd2;

  localparam logic [10:0] MAX_THRESHOLD = 11'd1024;
  localparam logic [6:0]  MAX_BURST     = 7'd64;
  localparam logic [12:0] MAX_COOLDOWN  = 13'd4096;

  typedef struct packed {
    op_t        op;
    logic [8:0] reasons;
    logic       obs_ok;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic        is_active;
    logic        is_exhausted;
    logic        in_cooldown;
    logic        send_request;
    logic [8:0]  active_reasons;
    logic [31:0] generation_out;
    logic [11:0] cooldown_left;
    logic [6:0]  attempt_number;
  } result_t;

endpackage

### hdl/rrc_front.sv
// front end: takes input words and classifies them for the back end
// depends on rrc_pkg
module rrc_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         op,
  input  logic [8:0]         reason_bits,
  input  logic [31:0]        frame_number,
  input  logic signed [31:0] base_frame,
  input  logic               q_full,
  output logic               push,
  output rrc_pkg::item_t     item
);
  import rrc_pkg::*;

  logic [31:0] base_raw;
  logic        base_pos;
  logic        no_reasons;
  logic        ok;

  assign base_raw   = $unsigned(base_frame);
  assign base_pos   = (base_raw != 32'd0) && !base_raw[31];
  assign no_reasons = (reason_bits == 9'd0);

  always_comb begin
    case (op)
      OP_DELTA_OK:    ok = no_reasons && base_pos && (base_raw < frame_number);
      OP_KEY_OK:      ok = no_reasons && !base_pos;
      OP_LEGACY_FAIL: ok = !no_reasons;
      OP_CANON_FAIL:  ok = !no_reasons;
      OP_FORCE:       ok = !no_reasons;
      OP_CANON_OK:    ok = no_reasons;
      default:        ok = 1'b0;
    endcase
  end

  assign in_ready     = !q_full;
  assign push         = in_valid && !q_full;
  assign item.op      = op;
  assign item.reasons = reason_bits;
  assign item.obs_ok  = ok;

endmodule

### hdl/rrc_queue.sv
// short queue between front and back end
// depends on rrc_pkg
module rrc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rrc_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output rrc_pkg::item_t rd_item
);
  import rrc_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

  assign full    = (count == CNT_FULL);
  assign q_valid = (count != '0);
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/rrc_back.sv
// back end: config registers, request state, decision logic, result register
// depends on rrc_pkg
module rrc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  rrc_pkg::item_t    q_item,
  output logic              q_pop,
  input  logic              cfg_valid,
  input  rrc_pkg::reg_idx_t cfg_index,
  input  logic [12:0]       cfg_data,
  output rrc_pkg::result_t  res,
  output logic              res_valid,
  input  logic              res_ready
);
  import rrc_pkg::*;

  logic [10:0] legacy_threshold;
  logic [10:0] canonical_threshold;
  logic [6:0]  burst_limit;
  logic [12:0] cooldown_ticks;

  logic                request_active, request_active_next;
  logic                gen_exhausted, gen_exhausted_next;
  logic [GEN_BITS-1:0] generation, generation_next;
  logic [8:0]          pending_reasons, pending_reasons_next;
  logic [6:0]          burst_attempts, burst_attempts_next;
  logic [11:0]         cooldown_count, cooldown_count_next;
  logic [10:0]         legacy_streak, legacy_streak_next;
  logic [10:0]         canonical_streak, canonical_streak_next;
  result_t             res_next;

  logic                 regs_ok;
  logic                 state_fits;
  logic                 arm_hit;
  logic [12:0]          ck_m1;
  logic [6:0]           ba_inc;
  logic [GEN_BITS+31:0] gen_ext;

  assign q_pop   = q_valid && (!res_valid || res_ready);
  assign ck_m1   = cooldown_ticks - 13'd1;
  assign ba_inc  = burst_attempts + 7'd1;
  assign gen_ext = {32'd0, generation};

  assign regs_ok = (legacy_threshold != 11'd0) && (legacy_threshold <= MAX_THRESHOLD) &&
                   (canonical_threshold != 11'd0) &&
                   (canonical_threshold <= MAX_THRESHOLD) &&
                   (burst_limit != 7'd0) && (burst_limit <= MAX_BURST) &&
                   (cooldown_ticks <= MAX_COOLDOWN);
  assign state_fits = (burst_attempts <= burst_limit) &&
                      ({1'b0, cooldown_count} <= cooldown_ticks);

  always_comb begin
    request_active_next   = request_active;
    gen_exhausted_next    = gen_exhausted;
    generation_next       = generation;
    pending_reasons_next  = pending_reasons;
    burst_attempts_next   = burst_attempts;
    cooldown_count_next   = cooldown_count;
    legacy_streak_next    = legacy_streak;
    canonical_streak_next = canonical_streak;
    res_next              = '0;
    arm_hit               = 1'b0;

    if (!regs_ok || !state_fits) begin
      res_next.status = ST_CFG;
    end else if (q_item.op == OP_TICK) begin
      if (gen_exhausted) begin
        res_next.is_exhausted = 1'b1;
      end else if (request_active) begin
        res_next.is_active      = 1'b1;
        res_next.active_reasons = pending_reasons;
        res_next.generation_out = gen_ext[31:0];
        if (cooldown_count != 12'd0) begin
          cooldown_count_next    = cooldown_count - 12'd1;
          res_next.in_cooldown   = 1'b1;
          res_next.cooldown_left = cooldown_count - 12'd1;
        end else if (burst_attempts >= burst_limit) begin
          if (cooldown_ticks != 13'd0) begin
            burst_attempts_next    = 7'd0;
            cooldown_count_next    = ck_m1[11:0];
            res_next.in_cooldown   = 1'b1;
            res_next.cooldown_left = ck_m1[11:0];
          end else begin
            burst_attempts_next     = 7'd1;
            res_next.send_request   = 1'b1;
            res_next.attempt_number = 7'd1;
          end
        end else begin
          burst_attempts_next     = ba_inc;
          res_next.send_request   = 1'b1;
          res_next.attempt_number = ba_inc;
        end
      end
    end else if (!q_item.obs_ok) begin
      res_next.status = ST_BAD;
    end else begin
      case (q_item.op)
        OP_DELTA_OK: begin
          legacy_streak_next = 11'd0;
        end
        OP_KEY_OK: begin
          legacy_streak_next    = 11'd0;
          canonical_streak_next = 11'd0;
          request_active_next   = 1'b0;
          pending_reasons_next  = 9'd0;
          burst_attempts_next   = 7'd0;
          cooldown_count_next   = 12'd0;
        end
        OP_LEGACY_FAIL: begin
          legacy_streak_next = (&legacy_streak) ? legacy_streak : legacy_streak + 11'd1;
          arm_hit            = (legacy_streak_next >= legacy_threshold);
        end
        OP_CANON_OK: begin
          canonical_streak_next = 11'd0;
        end
        OP_CANON_FAIL: begin
          canonical_streak_next = (&canonical_streak) ? canonical_streak
                                                      : canonical_streak + 11'd1;
          arm_hit               = (canonical_streak_next >= canonical_threshold);
        end
        default: begin
          arm_hit = 1'b1;
        end
      endcase

      if (arm_hit) begin
        if (request_active) begin
          pending_reasons_next = pending_reasons | q_item.reasons;
        end else if (&generation) begin
          pending_reasons_next = 9'd0;
          gen_exhausted_next   = 1'b1;
          res_next.status      = ST_EXH;
        end else begin
          generation_next      = generation + 1'b1;
          request_active_next  = 1'b1;
          burst_attempts_next  = 7'd0;
          cooldown_count_next  = 12'd0;
          pending_reasons_next = pending_reasons | q_item.reasons;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      legacy_threshold    <= LEGACY_THR_RST;
      canonical_threshold <= CANON_THR_RST;
      burst_limit         <= BURST_RST;
      cooldown_ticks      <= COOLDOWN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LEGACY_THR: legacy_threshold    <= cfg_data[10:0];
        REG_CANON_THR:  canonical_threshold <= cfg_data[10:0];
        REG_BURST:      burst_limit         <= cfg_data[6:0];
        REG_COOLDOWN:   cooldown_ticks      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      request_active   <= 1'b0;
      gen_exhausted    <= 1'b0;
      generation       <= '0;
      pending_reasons  <= 9'd0;
      burst_attempts   <= 7'd0;
      cooldown_count   <= 12'd0;
      legacy_streak    <= 11'd0;
      canonical_streak <= 11'd0;
      res_valid        <= 1'b0;
    end else begin
      if (q_pop) begin
        request_active   <= request_active_next;
        gen_exhausted    <= gen_exhausted_next;
        generation       <= generation_next;
        pending_reasons  <= pending_reasons_next;
        burst_attempts   <= burst_attempts_next;
        cooldown_count   <= cooldown_count_next;
        legacy_streak    <= legacy_streak_next;
        canonical_streak <= canonical_streak_next;
        res_valid        <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_send_not_cooldown: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.send_request && res.in_cooldown))
    else $error("send and cooldown in one result word");

  a_exhausted_sticky: assert property (@(posedge clk) disable iff (rst)
    gen_exhausted |=> gen_exhausted)
    else $error("exhausted flag cleared without reset");

  a_send_has_attempt: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.send_request) |-> (res.attempt_number != 7'd0))
    else $error("request sent with attempt zero");

  a_status_no_tick_flags: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.status != ST_OK)) |->
      !(res.is_active || res.send_request || res.in_cooldown))
    else $error("tick flags set on a non-ok status");

  a_no_result_from_empty: assert property (@(posedge clk) disable iff (rst)
    (!res_valid && !q_valid) |=> !res_valid)
    else $error("result word appeared with empty queue");
`endif

endmodule

### hdl/resync_request_controller.sv
// resync request controller top level: front end, queue, back end
// depends on rrc_pkg, rrc_front, rrc_queue, rrc_back
//
//   channel | signals                                   | direction
//   in      | in_valid in_ready op reason_bits          | word in
//           | frame_number base_frame                   |
//   out     | out_valid out_ready status is_active ...  | word out
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data    | register write
//
// one word per cycle sustained while out_ready stays high; a taken word is written into the
// two-entry queue, then the back end registers it into the result register once that is free
// synchronous reset clears all request state and loads register defaults 1, 3, 3, 2
// in_ready drops only when the queue is full; results hold until out_ready
// cfg_ready is always high
module resync_request_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         op,
  input  logic [8:0]         reason_bits,
  input  logic [31:0]        frame_number,
  input  logic signed [31:0] base_frame,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic               is_active,
  output logic               is_exhausted,
  output logic               in_cooldown,
  output logic               send_request,
  output logic [8:0]         active_reasons,
  output logic [31:0]        generation_out,
  output logic [11:0]        cooldown_left,
  output logic [6:0]         attempt_number,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [12:0]        cfg_data
);
  import rrc_pkg::*;

  logic    push;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  item_t   wr_item;
  item_t   rd_item;
  result_t res;

  assign cfg_ready = 1'b1;

  rrc_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .reason_bits  (reason_bits),
    .frame_number (frame_number),
    .base_frame   (base_frame),
    .q_full       (q_full),
    .push         (push),
    .item         (wr_item)
  );

  rrc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .q_valid (q_valid),
    .rd_item (rd_item)
  );

  rrc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (rd_item),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res),
    .res_valid (out_valid),
    .res_ready (out_ready)
  );

  assign status         = res.status;
  assign is_active      = res.is_active;
  assign is_exhausted   = res.is_exhausted;
  assign in_cooldown    = res.in_cooldown;
  assign send_request   = res.send_request;
  assign active_reasons = res.active_reasons;
  assign generation_out = res.generation_out;
  assign cooldown_left  = res.cooldown_left;
  assign attempt_number = res.attempt_number;

endmodule

### bench/tb_resync_request_controller.sv
`timescale 1ns / 100ps
// testbench for resync_request_controller: directed and random event words, checked
// against a scoreboard that tracks streaks, request arming, bursts and cooldown
// depends on rrc_pkg and the rtl top level resync_request_controller
import rrc_pkg::*;

class resync_scoreboard;
  logic [10:0]         legacy_thr;
  logic [10:0]         canon_thr;
  logic [6:0]          burst_max;
  logic [12:0]         cool_ticks;
  logic                req_on;
  logic                exhausted;
  logic [GEN_BITS-1:0] gen;
  logic [8:0]          reasons_acc;
  logic [6:0]          attempts;
  logic [11:0]         cool_cnt;
  logic [10:0]         legacy_run;
  logic [10:0]         canon_run;
  result_t             expected_results[$];
  int                  errors;

  function new();
    legacy_thr  = LEGACY_THR_RST;
    canon_thr   = CANON_THR_RST;
    burst_max   = BURST_RST;
    cool_ticks  = COOLDOWN_RST;
    req_on      = 1'b0;
    exhausted   = 1'b0;
    gen         = '0;
    reasons_acc = '0;
    attempts    = '0;
    cool_cnt    = '0;
    legacy_run  = '0;
    canon_run   = '0;
    errors      = 0;
  endfunction

  function void apply_reg(reg_idx_t idx, logic [12:0] data);
    case (idx)
      REG_LEGACY_THR: legacy_thr = data[10:0];
      REG_CANON_THR:  canon_thr  = data[10:0];
      REG_BURST:      burst_max  = data[6:0];
      REG_COOLDOWN:   cool_ticks = data;
      default: ;
    endcase
  endfunction

  function status_t arm(logic [8:0] rsn);
    reasons_acc |= rsn;
    if (req_on) return ST_OK;
    if (gen == '1) begin
      reasons_acc = '0;
      exhausted = 1'b1;
      return ST_EXH;
    end
    gen++;
    req_on   = 1'b1;
    attempts = '0;
    cool_cnt = '0;
    return ST_OK;
  endfunction

  function result_t predict_event(op_t o, logic [8:0] rsn, logic [31:0] frame,
                                  logic [31:0] base);
    result_t r;
    logic    base_pos;
    logic    valid_obs;
    logic    hold_send;
    r = '0;
    if (legacy_thr < 1 || legacy_thr > MAX_THRESHOLD || canon_thr < 1 ||
        canon_thr > MAX_THRESHOLD || burst_max < 1 || burst_max > MAX_BURST ||
        cool_ticks > MAX_COOLDOWN || attempts > burst_max || cool_cnt > cool_ticks) begin
      r.status = ST_CFG;
      return r;
    end
    if (o == OP_TICK) begin
      if (exhausted) begin
        r.is_exhausted = 1'b1;
      end else if (req_on) begin
        r.is_active      = 1'b1;
        r.active_reasons = reasons_acc;
        r.generation_out = 32'(gen);
        if (cool_cnt != 0) begin
          cool_cnt--;
          r.in_cooldown   = 1'b1;
          r.cooldown_left = cool_cnt;
        end else begin
          hold_send = 1'b0;
          if (attempts >= burst_max) begin
            attempts = '0;
            if (cool_ticks != 0) begin
              cool_cnt        = 12'(cool_ticks - 13'd1);
              r.in_cooldown   = 1'b1;
              r.cooldown_left = cool_cnt;
              hold_send       = 1'b1;
            end
          end
          if (!hold_send) begin
            attempts++;
            r.send_request   = 1'b1;
            r.attempt_number = attempts;
          end
        end
      end
      return r;
    end
    base_pos = (base != 0) && !base[31];
    case (o)
      OP_DELTA_OK:    valid_obs = (rsn == 0) && base_pos && (base < frame);
      OP_KEY_OK:      valid_obs = (rsn == 0) && !base_pos;
      OP_LEGACY_FAIL,
      OP_CANON_FAIL,
      OP_FORCE:       valid_obs = (rsn != 0);
      OP_CANON_OK:    valid_obs = (rsn == 0);
      default:        valid_obs = 1'b0;
    endcase
    if (!valid_obs) begin
      r.status = ST_BAD;
      return r;
    end
    case (o)
      OP_DELTA_OK: legacy_run = '0;
      OP_KEY_OK: begin
        legacy_run  = '0;
        canon_run   = '0;
        req_on      = 1'b0;
        reasons_acc = '0;
        attempts    = '0;
        cool_cnt    = '0;
      end
      OP_LEGACY_FAIL: begin
        if (legacy_run != '1) legacy_run++;
        if (legacy_run >= legacy_thr) r.status = arm(rsn);
      end
      OP_CANON_OK: canon_run = '0;
      OP_CANON_FAIL: begin
        if (canon_run != '1) canon_run++;
        if (canon_run >= canon_thr) r.status = arm(rsn);
      end
      default: r.status = arm(rsn);
    endcase
    return r;
  endfunction

  function void note_event(op_t o, logic [8:0] rsn, logic [31:0] frame, logic [31:0] base);
    expected_results.push_back(predict_event(o, rsn, frame, base));
  endfunction

  function void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result word, expected none, actual status %0d",
               $time, got.status);
      return;
    end
    want = expected_results.pop_front();
    check_field("status", 32'(want.status), 32'(got.status));
    check_field("is_active", 32'(want.is_active), 32'(got.is_active));
    check_field("is_exhausted", 32'(want.is_exhausted), 32'(got.is_exhausted));
    check_field("in_cooldown", 32'(want.in_cooldown), 32'(got.in_cooldown));
    check_field("send_request", 32'(want.send_request), 32'(got.send_request));
    check_field("active_reasons", 32'(want.active_reasons), 32'(got.active_reasons));
    check_field("generation_out", want.generation_out, got.generation_out);
    check_field("cooldown_left", 32'(want.cooldown_left), 32'(got.cooldown_left));
    check_field("attempt_number", 32'(want.attempt_number), 32'(got.attempt_number));
  endfunction

  function int pending();
    return expected_results.size();
  endfunction
endclass

module tb_resync_request_controller;
  localparam int       LONG_HOLD    = 80;
  localparam int       DRAIN_CYCLES = 6;
  localparam reg_idx_t REG_UNUSED   = 3'd6;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  op_t                op = OP_TICK;
  logic [8:0]         reason_bits = '0;
  logic [31:0]        frame_number = '0;
  logic signed [31:0] base_frame = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic               is_active;
  logic               is_exhausted;
  logic               in_cooldown;
  logic               send_request;
  logic [8:0]         active_reasons;
  logic [31:0]        generation_out;
  logic [11:0]        cooldown_left;
  logic [6:0]         attempt_number;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  reg_idx_t           cfg_index = REG_LEGACY_THR;
  logic [12:0]        cfg_data = '0;

  resync_scoreboard tracker;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit hold_busy = 1'b0;
  int tx_mode = 1;

  logic [12:0] bad_cfg [9][4] = '{
    '{13'd0, 13'd3, 13'd3, 13'd2}, '{13'd1025, 13'd3, 13'd3, 13'd2},
    '{13'd1, 13'd0, 13'd3, 13'd2}, '{13'd1, 13'h1FFF, 13'd3, 13'd2},
    '{13'd1, 13'd3, 13'd0, 13'd2}, '{13'd1, 13'd3, 13'd65, 13'd2},
    '{13'd1, 13'd3, 13'd127, 13'd2}, '{13'd1, 13'd3, 13'd3, 13'd4097},
    '{13'd1, 13'd3, 13'd3, 13'h1FFF}
  };

  resync_request_controller dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) tracker.note_event(op, reason_bits, frame_number, base_frame);
      if (out_valid && out_ready)
        tracker.check_result({status, is_active, is_exhausted, in_cooldown, send_request,
                              active_reasons, generation_out, cooldown_left, attempt_number});
    end
  end

  // receiver: random stall bursts, quiet stretches, one long hold on request
  initial begin
    int stall_left;
    int rx_mode;
    int mode_age;
    stall_left = 0;
    rx_mode = 1;
    mode_age = 0;
    forever begin
      @(posedge clk);
      mode_age++;
      if (mode_age == 150) begin
        mode_age = 0;
        rx_mode = $urandom_range(0, 2);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_busy = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0) begin
        hold_busy = 1'b0;
        if (!calm && rx_mode != 0 && $urandom_range(0, 5) == 0)
          stall_left = $urandom_range(1, 19);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic int tx_gap();
    if (calm || hold_busy || tx_mode == 0) return 0;
    if ($urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 19);
  endfunction

  task automatic send_word(op_t o, logic [8:0] r, logic [31:0] f, logic [31:0] b);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= o;
    reason_bits  <= r;
    frame_number <= f;
    base_frame   <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_event();
    int          pick;
    op_t         o;
    logic [8:0]  r;
    logic [31:0] f;
    logic [31:0] b;
    pick = $urandom_range(0, 99);
    o = OP_TICK;
    r = '0;
    f = $urandom;
    b = $urandom;
    if (pick < 12) begin
      o = OP_CANON_FAIL;
      r = 9'($urandom_range(1, 511));
    end else if (pick < 22) begin
      o = OP_LEGACY_FAIL;
      r = 9'($urandom_range(1, 511));
    end else if (pick < 30) begin
      o = OP_CANON_OK;
    end else if (pick < 38) begin
      o = OP_DELTA_OK;
      b = $urandom_range(1, 32'h7FFFFFFE);
      f = b + 32'd1 + ($urandom & 32'h7FFFFFFF);
    end else if (pick < 44) begin
      o = OP_KEY_OK;
      b = ($urandom_range(0, 3) == 0) ? 32'd0 : {1'b1, 31'($urandom)};
    end else if (pick < 50) begin
      o = OP_FORCE;
      r = 9'($urandom_range(1, 511));
    end else if (pick < 58) begin
      o = op_t'($urandom_range(0, 7));
      r = 9'($urandom_range(0, 511));
    end
    send_word(o, r, f, b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [12:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_config(logic [12:0] legacy, logic [12:0] canon, logic [12:0] burst,
                             logic [12:0] cool);
    cfg_write(REG_LEGACY_THR, legacy);
    cfg_write(REG_CANON_THR, canon);
    cfg_write(REG_BURST, burst);
    cfg_write(REG_COOLDOWN, cool);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    tracker = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cfg_write(REG_UNUSED, '1);
    cfg_valid <= 1'b0;
    @(posedge clk);

    // directed words at reset settings
    send_word(OP_INVALID, 9'h000, 32'd0, 32'd0);
    send_word(OP_DELTA_OK, 9'h000, 32'd2, 32'd1);
    send_word(OP_DELTA_OK, 9'h000, 32'hFFFFFFFF, 32'h7FFFFFFF);
    send_word(OP_DELTA_OK, 9'h000, 32'd5, 32'd0);
    send_word(OP_DELTA_OK, 9'h000, 32'hFFFFFFFF, 32'h80000000);
    send_word(OP_DELTA_OK, 9'h000, 32'd5, 32'd5);
    send_word(OP_DELTA_OK, 9'h001, 32'd2, 32'd1);
    send_word(OP_KEY_OK, 9'h000, 32'd0, 32'd0);
    send_word(OP_KEY_OK, 9'h000, 32'h80000000, 32'h80000000);
    send_word(OP_KEY_OK, 9'h000, 32'd9, 32'd1);
    send_word(OP_KEY_OK, 9'h1FF, 32'd9, 32'hFFFFFFFF);
    send_word(OP_LEGACY_FAIL, 9'h000, 32'd3, 32'd1);
    send_word(OP_TICK, 9'h1FF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_word(OP_LEGACY_FAIL, 9'h1FF, 32'd3, 32'd1);
    repeat (6) send_word(OP_TICK, 9'h000, 32'd0, 32'd0);
    send_word(OP_CANON_OK, 9'h001, 32'd0, 32'd0);
    send_word(OP_FORCE, 9'h000, 32'd0, 32'd0);
    send_word(OP_FORCE, 9'h100, 32'd0, 32'd0);
    send_word(OP_KEY_OK, 9'h000, 32'd0, 32'd0);
    repeat (3) send_word(OP_CANON_FAIL, 9'h055, 32'd0, 32'd0);
    send_word(OP_TICK, 9'h000, 32'd0, 32'd0);
    send_word(OP_KEY_OK, 9'h000, 32'd0, 32'd0);
    drain();

    // state left beyond a lowered burst limit, then beyond a lowered cooldown
    load_config(13'd1, 13'd3, 13'd10, 13'd100);
    send_word(OP_FORCE, 9'h0AA, 32'd0, 32'd0);
    repeat (6) send_word(OP_TICK, 9'h000, 32'd0, 32'd0);
    drain();
    load_config(13'd1, 13'd3, 13'd2, 13'd100);
    repeat (2) send_word(OP_TICK, 9'h000, 32'd0, 32'd0);
    send_word(OP_KEY_OK, 9'h000, 32'd0, 32'd0);
    drain();
    load_config(13'd1, 13'd3, 13'd6, 13'd100);
    send_word(OP_TICK, 9'h000, 32'd0, 32'd0);
    drain();
    load_config(13'd1, 13'd3, 13'd6, 13'd5);
    send_word(OP_TICK, 9'h000, 32'd0, 32'd0);
    drain();
    load_config(13'd1, 13'd3, 13'd6, MAX_COOLDOWN);
    repeat (2) send_word(OP_TICK, 9'h000, 32'd0, 32'd0);
    drain();

    // registers out of range
    for (int i = 0; i < 9; i++) begin
      load_config(bad_cfg[i][0], bad_cfg[i][1], bad_cfg[i][2], bad_cfg[i][3]);
      repeat (2) send_random_event();
      drain();
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: load_config(13'(MAX_THRESHOLD), 13'(MAX_THRESHOLD), 13'(MAX_BURST), MAX_COOLDOWN);
        1: load_config(13'd1, 13'd1, 13'd1, 13'd0);
        default: begin
          if ($urandom_range(0, 2) == 0)
            load_config(13'($urandom_range(1, 1024)), 13'($urandom_range(1, 1024)),
                        13'($urandom_range(1, 64)), 13'($urandom_range(0, 4096)));
          else
            load_config(13'($urandom_range(1, 4)), 13'($urandom_range(1, 5)),
                        13'($urandom_range(1, 6)), 13'($urandom_range(0, 8)));
        end
      endcase
      calm = (ph == 7);
      for (int k = 0; k < 60; k++) begin
        if (k % 20 == 0) tx_mode = $urandom_range(0, 2);
        if (ph == 2 && k == 20) hold_req = 1'b1;
        send_random_event();
      end
    end

    drain();
    if (tracker.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

### files.f
hdl/rrc_pkg.sv
hdl/rrc_front.sv
hdl/rrc_queue.sv
hdl/rrc_back.sv
hdl/resync_request_controller.sv
bench/tb_resync_request_controller.sv
